// ===== sv/lhbe_pkg.sv =====
// Package for the LRU heap budget evictor: request and status codes, widths.
// No dependencies.
package lhbe_pkg;
    localparam int DEF_ENTRIES = 16;
    localparam int CNT_W = 36;
    localparam int SIZE_W = 32;
    localparam logic [CNT_W-1:0] LIMIT_RST = 36'd268435456;
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_TOUCH = 3'd2;
    localparam logic [2:0] REQ_LOCK = 3'd3;
    localparam logic [2:0] REQ_LOAD = 3'd4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LOCKED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;
endpackage

// ===== sv/lhbe_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module lhbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/lru_heap_budget_evictor.sv =====
// Top level of the LRU heap budget evictor: request sequencer, flag and rank
// registers, and the entry size memory (lhbe_ram). Uses lhbe_pkg.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata: req_type, handle, block_size, lock_value
//  m_axis   | out | tdata: status, result_handle, evicted, heap_used, total_used,
//           |     |        live_count; tlast: last
//  cfg      | in  | heap_limit write
//
// Alloc searches for the lowest free entry and then sweeps the ranks, one entry
// per cycle each. Release and touch read the entry size, then sweep the ranks;
// lock, unknown types and invalid handles stop after the size read. A load walks
// ranks oldest first, once for unlocked then once for locked entries, searching
// one entry per cycle; each eviction reads the victim's size and holds the walk
// until its result item is taken.
// Reset clears the valid, disk and lock flags and the counters at once.
// A waiting result holds the sequencer; new items wait until the request ends.
module lru_heap_budget_evictor
    import lhbe_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[2:0], handle[6:3], block_size[38:7], lock_value[39]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], result_handle[5:2], evicted[6], heap_used[42:7],
    // total_used[78:43], live_count[83:79], zero fill
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [35:0] cfg_wdata
);
    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int LW = $clog2(NUM_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIND = 4'd1;   // alloc: search free slot
    localparam logic [3:0] S_SWEEP = 4'd2;  // rank update sweep
    localparam logic [3:0] S_RDSZ = 4'd3;   // wait size read of handle
    localparam logic [3:0] S_WALK = 4'd4;   // load: search entry at rank
    localparam logic [3:0] S_WRD = 4'd5;    // load: wait candidate size
    localparam logic [3:0] S_OUT = 4'd6;    // result pending
    localparam logic [3:0] S_FIN = 4'd7;    // final result pending

    localparam logic [1:0] SW_ALLOC = 2'd0;
    localparam logic [1:0] SW_REL = 2'd1;
    localparam logic [1:0] SW_TOUCH = 2'd2;

    logic [3:0] state_reg;
    logic [NUM_ENTRIES-1:0] valid_reg, disk_reg, lock_reg;
    logic [IW-1:0] rank_reg [NUM_ENTRIES];
    logic [CNT_W-1:0] heap_reg, total_reg, limit_reg;
    logic [LW-1:0] live_reg;
    logic [2:0] req_reg;
    logic [IW-1:0] h_reg, idx_reg, my_rank_reg;
    logic hbad_reg;   // handle lies beyond the table
    logic [SIZE_W-1:0] size_reg;
    logic lockv_reg, phase_reg;
    logic [1:0] sw_reg;
    logic [LW-1:0] r_reg;   // current walk rank plus one
    logic [1:0] st_reg;
    logic [IW-1:0] oh_reg;
    logic ev_reg;

    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;

    lhbe_ram #(.WIDTH(SIZE_W), .DEPTH(NUM_ENTRIES)) u_size (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(size_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic in_hs, out_hs, h_ok, over;
    logic [IW-1:0] in_h;
    logic [CNT_W-1:0] need;
    logic [CNT_W:0] sum_w;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_hs = s_axis_tvalid && s_axis_tready;
    assign in_h = IW'(s_axis_tdata[6:3]);
    assign m_axis_tvalid = (state_reg == S_OUT) || (state_reg == S_FIN);
    assign m_axis_tlast = (state_reg == S_FIN);
    assign out_hs = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {4'd0, 5'(live_reg), total_reg, heap_reg, ev_reg,
                           4'(oh_reg), st_reg};
    assign h_ok = !hbad_reg && valid_reg[h_reg];
    assign need = heap_reg + CNT_W'(size_reg);
    // The budget test keeps the carry of heap plus request size.
    assign sum_w = {1'b0, heap_reg} + (CNT_W+1)'(size_reg);
    assign over = sum_w > {1'b0, limit_reg};

    logic cand;
    assign cand = valid_reg[idx_reg] && (idx_reg != h_reg)
               && (LW'(rank_reg[idx_reg]) == r_reg - 1'b1)
               && (lock_reg[idx_reg] == phase_reg);

    assign ram_we = (state_reg == S_FIND) && !valid_reg[idx_reg];
    assign ram_waddr = idx_reg;
    // The size of the addressed entry is read at the accepting edge.
    assign ram_raddr = (state_reg == S_IDLE) ? in_h : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            disk_reg <= '0;
            lock_reg <= '0;
            heap_reg <= '0;
            total_reg <= '0;
            live_reg <= '0;
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_hs)
                    begin
                        req_reg <= s_axis_tdata[2:0];
                        h_reg <= in_h;
                        hbad_reg <= ({28'd0, s_axis_tdata[6:3]} >= 32'(NUM_ENTRIES));
                        size_reg <= s_axis_tdata[38:7];
                        lockv_reg <= s_axis_tdata[39];
                        idx_reg <= '0;
                        st_reg <= ST_OK;
                        oh_reg <= '0;
                        ev_reg <= 1'b0;
                        state_reg <= (s_axis_tdata[2:0] == REQ_ALLOC) ? S_FIND : S_RDSZ;
                    end
                end
                S_FIND:
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        h_reg <= idx_reg;
                        oh_reg <= idx_reg;
                        sw_reg <= SW_ALLOC;
                        idx_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        st_reg <= ST_FULL;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RDSZ:
                begin
                    // size of the addressed entry is now on ram_rdata
                    my_rank_reg <= rank_reg[h_reg];
                    idx_reg <= '0;
                    if (req_reg > REQ_LOAD)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (!h_ok)
                    begin
                        st_reg <= ST_BAD;
                        state_reg <= S_FIN;
                    end
                    else if (req_reg == REQ_RELEASE)
                    begin
                        total_reg <= total_reg - CNT_W'(ram_rdata);
                        if (!disk_reg[h_reg])
                        begin
                            heap_reg <= heap_reg - CNT_W'(ram_rdata);
                        end
                        valid_reg[h_reg] <= 1'b0;
                        disk_reg[h_reg] <= 1'b0;
                        lock_reg[h_reg] <= 1'b0;
                        live_reg <= live_reg - 1'b1;
                        sw_reg <= SW_REL;
                        state_reg <= S_SWEEP;
                    end
                    else if (req_reg == REQ_TOUCH)
                    begin
                        sw_reg <= SW_TOUCH;
                        state_reg <= S_SWEEP;
                    end
                    else if (req_reg == REQ_LOCK)
                    begin
                        lock_reg[h_reg] <= lockv_reg;
                        state_reg <= S_FIN;
                    end
                    else if (!disk_reg[h_reg])
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        r_reg <= live_reg;
                        state_reg <= S_WALK;
                    end
                end
                S_SWEEP:
                begin
                    case (sw_reg)
                        SW_ALLOC:
                        begin
                            if (valid_reg[idx_reg])
                            begin
                                rank_reg[idx_reg] <= rank_reg[idx_reg] + 1'b1;
                            end
                        end
                        SW_REL:
                        begin
                            if (valid_reg[idx_reg] && rank_reg[idx_reg] > my_rank_reg)
                            begin
                                rank_reg[idx_reg] <= rank_reg[idx_reg] - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (valid_reg[idx_reg] && idx_reg != h_reg
                                && rank_reg[idx_reg] < my_rank_reg)
                            begin
                                rank_reg[idx_reg] <= rank_reg[idx_reg] + 1'b1;
                            end
                        end
                    endcase
                    if (idx_reg == LAST_IDX)
                    begin
                        if (sw_reg != SW_REL)
                        begin
                            rank_reg[h_reg] <= '0;
                        end
                        if (sw_reg == SW_ALLOC)
                        begin
                            valid_reg[h_reg] <= 1'b1;
                            disk_reg[h_reg] <= 1'b0;
                            lock_reg[h_reg] <= 1'b0;
                            live_reg <= live_reg + 1'b1;
                            total_reg <= total_reg + CNT_W'(size_reg);
                            heap_reg <= heap_reg + CNT_W'(size_reg);
                        end
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WALK:
                begin
                    if (r_reg == '0)
                    begin
                        if (phase_reg)
                        begin
                            // walk ran out: charge the heap even when over
                            heap_reg <= need;
                            disk_reg[h_reg] <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            phase_reg <= 1'b1;
                            r_reg <= live_reg;
                            idx_reg <= '0;
                        end
                    end
                    else if (cand)
                    begin
                        if (!over)
                        begin
                            heap_reg <= need;
                            disk_reg[h_reg] <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else if (phase_reg)
                        begin
                            st_reg <= ST_LOCKED;
                            state_reg <= S_FIN;
                        end
                        else if (!disk_reg[idx_reg])
                        begin
                            state_reg <= S_WRD;
                        end
                        else
                        begin
                            r_reg <= r_reg - 1'b1;
                            idx_reg <= '0;
                        end
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        r_reg <= r_reg - 1'b1;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WRD:
                begin
                    disk_reg[idx_reg] <= 1'b1;
                    heap_reg <= heap_reg - CNT_W'(ram_rdata);
                    oh_reg <= idx_reg;
                    ev_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_hs)
                    begin
                        ev_reg <= 1'b0;
                        oh_reg <= '0;
                        r_reg <= r_reg - 1'b1;
                        idx_reg <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_FIN:
                begin
                    if (out_hs)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, live_reg} <= (LW+1)'(NUM_ENTRIES))
        else $error("live count beyond table size");
    a_live_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'($countones(valid_reg)) == 32'(live_reg)))
        else $error("live count disagrees with valid flags");
    a_ev_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !ev_reg)
        else $error("eviction reported on final item");
`endif
endmodule
